// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge out of reset
`define CHK_HOLDS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen out of reset
`define CHK_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== src/rgmm_pkg.sv =====
package rgmm_pkg;

  localparam int COST_W      = 8;
  localparam int VAL_W       = 7;
  localparam int LIDX_W      = 8;
  localparam int RIDX_W      = 9;
  localparam int IDX_W       = 12;
  localparam int COORD_W     = 14;
  localparam int TRIG_W      = 16;
  localparam int REL_W       = 9;
  localparam int PROD_W      = REL_W + TRIG_W;
  localparam int SUM_W       = PROD_W + 1;
  localparam int Q14_FRAC    = 14;
  localparam int Q14_BIAS    = (1 << Q14_FRAC) - 1;
  localparam int OFFS_W      = 10;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_INDEX_W-1:0] REG_COS        = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SIN        = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CENTER_COL = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CENTER_ROW = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_COL = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_ROW = 3'd5;

  localparam logic [1:0] CMD_SKIP  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_MERGE = 2'd2;

  typedef struct packed {
    logic [1:0]       op;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] cost;
  } cmd_t;

endpackage

// ===== src/rgmm_if.sv =====
interface rgmm_req_if import rgmm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [LIDX_W-1:0]        local_row;
  logic [LIDX_W-1:0]        local_col;
  logic signed [COST_W-1:0] cost;
  logic [RIDX_W-1:0]        read_row;
  logic [RIDX_W-1:0]        read_col;

  modport source (output valid, req_type, local_row, local_col, cost, read_row, read_col,
                  input ready);
  modport sink (input valid, req_type, local_row, local_col, cost, read_row, read_col,
                output ready);
endinterface

interface rgmm_rsp_if import rgmm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] cell_value;
  logic             in_bounds;
  logic             written;

  modport source (output valid, cell_value, in_bounds, written, input ready);
  modport sink (input valid, cell_value, in_bounds, written, output ready);
endinterface

// ===== src/rgmm_ram.sv =====
module rgmm_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 262144
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/rgmm_front.sv =====
module rgmm_front import rgmm_pkg::*; #(
  parameter int GLOBAL_DIM = 512
) (
  input  logic                   clk,
  input  logic                   rst,
  rgmm_req_if.sink               req,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   clearing,
  input  logic                   q_full,
  output logic                   q_push,
  output cmd_t                   q_cmd
);

  localparam logic [COORD_W-2:0] GRID_LIM = (COORD_W-1)'(GLOBAL_DIM);

  logic signed [TRIG_W-1:0] cos_q14;
  logic signed [TRIG_W-1:0] sin_q14;
  logic [LIDX_W-1:0]        center_col;
  logic [LIDX_W-1:0]        center_row;
  logic [OFFS_W-1:0]        offset_col;
  logic [OFFS_W-1:0]        offset_row;

  // stage a: classify and multiply
  logic                     a_valid;
  logic                     a_read;
  logic                     a_skip;
  logic [RIDX_W-1:0]        a_rr;
  logic [RIDX_W-1:0]        a_rc;
  logic [VAL_W-1:0]         a_cost;
  logic signed [PROD_W-1:0] p_xc, p_ys, p_xs, p_yc;

  // stage b: finished command
  logic b_valid;
  cmd_t b_cmd;
  cmd_t b_cmd_next;

  logic a_en;
  logic b_en;
  logic signed [REL_W-1:0] relx;
  logic signed [REL_W-1:0] rely;
  logic [SUM_W-1:0]   tx_raw, ty_raw, tx_adj, ty_adj;
  logic [COORD_W-1:0] tx_q, ty_q, col, row;
  logic               col_ok, row_ok, rd_ok;

  assign q_push    = b_valid && !q_full;
  assign b_en      = !b_valid || !q_full;
  assign a_en      = !a_valid || b_en;
  assign req.ready = a_en && !clearing;
  assign q_cmd     = b_cmd;

  assign relx = $signed({1'b0, center_col}) - $signed({1'b0, req.local_col});
  assign rely = $signed({1'b0, center_row}) - $signed({1'b0, req.local_row});

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_q14    <= TRIG_W'(1 << Q14_FRAC);
      sin_q14    <= '0;
      center_col <= '0;
      center_row <= '0;
      offset_col <= '0;
      offset_row <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COS:        cos_q14    <= cfg_wdata;
        REG_SIN:        sin_q14    <= cfg_wdata;
        REG_CENTER_COL: center_col <= cfg_wdata[LIDX_W-1:0];
        REG_CENTER_ROW: center_row <= cfg_wdata[LIDX_W-1:0];
        REG_OFFSET_COL: offset_col <= cfg_wdata[OFFS_W-1:0];
        REG_OFFSET_ROW: offset_row <= cfg_wdata[OFFS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_en) begin
      a_valid <= req.valid && req.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (a_en) begin
      a_read <= req.req_type;
      a_skip <= req.cost[COST_W-1] || (req.cost[COST_W-2:0] == '0);
      a_rr   <= req.read_row;
      a_rc   <= req.read_col;
      a_cost <= req.cost[VAL_W-1:0];
      p_xc   <= PROD_W'(relx) * PROD_W'(cos_q14);
      p_ys   <= PROD_W'(rely) * PROD_W'(sin_q14);
      p_xs   <= PROD_W'(relx) * PROD_W'(sin_q14);
      p_yc   <= PROD_W'(rely) * PROD_W'(cos_q14);
    end
  end

  always_comb begin
    tx_raw = {p_xc[PROD_W-1], p_xc} - {p_ys[PROD_W-1], p_ys};
    ty_raw = {p_xs[PROD_W-1], p_xs} + {p_yc[PROD_W-1], p_yc};
    // truncate toward zero: bias negative sums before the shift
    tx_adj = tx_raw + (tx_raw[SUM_W-1] ? SUM_W'(Q14_BIAS) : '0);
    ty_adj = ty_raw + (ty_raw[SUM_W-1] ? SUM_W'(Q14_BIAS) : '0);
    tx_q = {{(COORD_W-(SUM_W-Q14_FRAC)){tx_adj[SUM_W-1]}}, tx_adj[SUM_W-1:Q14_FRAC]};
    ty_q = {{(COORD_W-(SUM_W-Q14_FRAC)){ty_adj[SUM_W-1]}}, ty_adj[SUM_W-1:Q14_FRAC]};
    col = {{(COORD_W-LIDX_W){1'b0}}, center_col} + tx_q
          - {{(COORD_W-OFFS_W){offset_col[OFFS_W-1]}}, offset_col};
    row = {{(COORD_W-LIDX_W){1'b0}}, center_row} + ty_q
          - {{(COORD_W-OFFS_W){offset_row[OFFS_W-1]}}, offset_row};
    col_ok = !col[COORD_W-1] && (col[COORD_W-2:0] < GRID_LIM);
    row_ok = !row[COORD_W-1] && (row[COORD_W-2:0] < GRID_LIM);
    rd_ok  = ((COORD_W-1)'(a_rr) < GRID_LIM) && ((COORD_W-1)'(a_rc) < GRID_LIM);

    b_cmd_next.op   = CMD_SKIP;
    b_cmd_next.row  = row[IDX_W-1:0];
    b_cmd_next.col  = col[IDX_W-1:0];
    b_cmd_next.cost = a_cost;
    if (a_read) begin
      b_cmd_next.row = IDX_W'(a_rr);
      b_cmd_next.col = IDX_W'(a_rc);
      if (rd_ok) begin
        b_cmd_next.op = CMD_READ;
      end
    end else if (!a_skip && col_ok && row_ok) begin
      b_cmd_next.op = CMD_MERGE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_en) begin
      b_cmd <= b_cmd_next;
    end
  end

endmodule

// ===== src/rgmm_fifo.sv =====
`include "assert_macros.svh"

module rgmm_fifo import rgmm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic empty
);

  cmd_t                   mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   count;

  assign full    = (count == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign pop_cmd = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `CHK_NEVER(a_push_full, clk, rst, push && full && !pop, "item pushed into full queue")
  `CHK_NEVER(a_pop_empty, clk, rst, pop && empty, "item popped from empty queue")

endmodule

// ===== src/rgmm_back.sv =====
`include "assert_macros.svh"

module rgmm_back import rgmm_pkg::*; #(
  parameter int GLOBAL_DIM = 512
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  cmd_t       q_cmd,
  output logic       q_pop,
  output logic       clearing,
  rgmm_rsp_if.source rsp
);

  localparam int CELLS  = GLOBAL_DIM * GLOBAL_DIM;
  localparam int ADDR_W = $clog2(CELLS);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [ADDR_W-1:0] clr_addr;
  cmd_t              cur;
  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [VAL_W-1:0]  rd_data;

  logic              out_valid;
  logic [VAL_W-1:0]  out_value;
  logic              out_inb;
  logic              out_written;

  logic              out_free;
  logic              finish;
  logic              raise;
  logic [VAL_W-1:0]  res_value;
  logic              res_inb;
  logic              res_wr;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [VAL_W-1:0]  ram_wdata;

  assign clearing = (state == ST_CLEAR);
  assign out_free = !out_valid || rsp.ready;
  assign q_pop    = (state == ST_IDLE) && !q_empty;
  assign finish   = (state == ST_EXEC) && out_free;
  assign rd_addr  = ADDR_W'(q_cmd.row) * ADDR_W'(GLOBAL_DIM) + ADDR_W'(q_cmd.col);

  assign rsp.valid      = out_valid;
  assign rsp.cell_value = out_value;
  assign rsp.in_bounds  = out_inb;
  assign rsp.written    = out_written;

  always_comb begin
    raise     = cur.cost > rd_data;
    res_value = '0;
    res_inb   = 1'b0;
    res_wr    = 1'b0;
    case (cur.op)
      CMD_READ: begin
        res_value = rd_data;
        res_inb   = 1'b1;
      end
      CMD_MERGE: begin
        res_value = raise ? cur.cost : rd_data;
        res_inb   = 1'b1;
        res_wr    = raise;
      end
      default: ;
    endcase
  end

  always_comb begin
    ram_we    = clearing || (finish && res_wr);
    ram_waddr = clearing ? clr_addr : cur_addr;
    ram_wdata = clearing ? '0 : cur.cost;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_addr == ADDR_W'(CELLS - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (q_pop) state_next = ST_EXEC;
      ST_EXEC:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (finish) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur      <= q_cmd;
      cur_addr <= rd_addr;
    end
    if (finish) begin
      out_value   <= res_value;
      out_inb     <= res_inb;
      out_written <= res_wr;
    end
  end

  // read at pop, merge and write back in the exec state once the output register is free
  rgmm_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CELLS)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (q_pop),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  `CHK_HOLDS(a_clear_quiet, clk, rst, clearing |-> (!out_valid && !q_pop),
             "item moved during grid clear")
  `CHK_HOLDS(a_written_inb, clk, rst, (out_valid && out_written) |-> out_inb,
             "written result outside grid")

endmodule

// ===== src/rotated_grid_max_merge_top.sv =====
// channel  dir  handshake      payload
// req      in   valid/ready    req_type, local_row, local_col, cost, read_row, read_col
// rsp      out  valid/ready    cell_value, in_bounds, written
// cfg      in   cfg_we         cfg_index, cfg_wdata
//
// front: two register stages (classify and rotate multiply, coordinates), then the queue push
// back: per item, one grid ram read at pop then the max merge write once the rsp register
// is free; the single-item read-modify-write takes no new item until the last one is done
// after reset the grid of GLOBAL_DIM*GLOBAL_DIM cells (262144 at 512) is cleared one cell a
// cycle, during which req.ready stays low
// a 4-entry command queue and the rsp output register let each side stall on its own
module rotated_grid_max_merge_top import rgmm_pkg::*; #(
  parameter int GLOBAL_DIM = 512
) (
  input  logic                   clk,
  input  logic                   rst,
  rgmm_req_if.sink               req,
  rgmm_rsp_if.source             rsp,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  logic clearing;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  cmd_t push_cmd;
  cmd_t pop_cmd;

  rgmm_front #(
    .GLOBAL_DIM (GLOBAL_DIM)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .clearing  (clearing),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  rgmm_fifo u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  rgmm_back #(
    .GLOBAL_DIM (GLOBAL_DIM)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_cmd    (pop_cmd),
    .q_pop    (q_pop),
    .clearing (clearing),
    .rsp      (rsp)
  );

endmodule
